FILE: sv/bss_pkg.sv
package bss_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = 16 + $clog2(MAX_POINTS);
  localparam int SQ_W       = 32 + $clog2(MAX_POINTS);

  // shared arithmetic unit widths
  localparam int OPND_W = 64;
  localparam int PROD_W = 2 * OPND_W;
  localparam int DVS_W  = 114;
  localparam int DVD_W  = DVS_W + 30;
  localparam int QUO_W  = 64;
  localparam int ROOT_W = OPND_W / 2;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_POINTS);
  localparam logic [15:0]      CORR_ONE = 16'd16384;

  typedef enum logic [4:0] {
    OP_MEANX, OP_MEANY,
    OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NN,
    OP_DXNN, OP_SQX, OP_DYNN, OP_SQY,
    OP_NSXY, OP_SXSY, OP_MAG2, OP_DXDY, OP_CDIV, OP_CSQ
  } op_t;

  typedef enum logic [1:0] {ST_ACC, ST_ISSUE, ST_WAIT, ST_FIN} state_t;

  typedef struct packed {
    logic acc_en;
    logic start;
    logic capture;
    logic load_out;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic empty;
    logic degen;
    logic out_busy;
  } stat_t;

endpackage

FILE: sv/bss_mul.sv
module bss_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bss_pkg::OPND_W-1:0] a,
  input  logic [bss_pkg::OPND_W-1:0] b,
  output logic                       done,
  output logic [bss_pkg::PROD_W-1:0] p
);
  import bss_pkg::*;

  localparam int CW = $clog2(OPND_W);

  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [PROD_W-1:0] a_r, p_r;
  logic [OPND_W-1:0] b_r;

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(OPND_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      a_r   <= PROD_W'(a);
      b_r   <= b;
      p_r   <= '0;
    end else if (busy_r) begin
      if (b_r[0]) p_r <= p_r + a_r;
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign p    = p_r;
endmodule

FILE: sv/bss_div.sv
module bss_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bss_pkg::DVD_W-1:0] dvd,
  input  logic [bss_pkg::DVS_W-1:0] dvs,
  output logic                      done,
  output logic [bss_pkg::QUO_W-1:0] quo
);
  import bss_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic             busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DVD_W-1:0] dvd_r;
  logic [QUO_W-1:0] quo_r;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      dvs_r <= dvs;
      dvd_r <= dvd;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

FILE: sv/bss_sqrt.sv
module bss_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bss_pkg::OPND_W-1:0] v,
  output logic                       done,
  output logic [bss_pkg::ROOT_W-1:0] root
);
  import bss_pkg::*;

  localparam int CW = $clog2(ROOT_W);

  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [OPND_W-1:0] v_r, res_r, bit_r, t;

  assign t = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(ROOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      v_r   <= v;
      res_r <= '0;
      bit_r <= OPND_W'(1) << (OPND_W - 2);
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_r   <= v_r - t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];
endmodule

FILE: sv/bss_dp.sv
module bss_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         x_sample,
  input  logic [15:0]         y_sample,
  input  bss_pkg::cmd_t       cmd,
  output bss_pkg::stat_t      stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [15:0]         mean_x_out,
  output logic [15:0]         mean_y_out,
  output logic [15:0]         stdev_x_out,
  output logic [15:0]         stdev_y_out,
  output logic signed [15:0]  correlation,
  output logic                degenerate
);
  import bss_pkg::*;

  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sx_r, sy_r;
  logic [SQ_W-1:0]   sxx_r, syy_r, sxy_r;
  logic [15:0]       mx_r, my_r, sdx_r, sdy_r, corr_r;
  logic [OPND_W-1:0] t1_r, dx_r, dy_r, nn_r, mag_r;
  logic              neg_r;
  logic [DVD_W-1:0]  num_r;
  logic [DVS_W-1:0]  den_r;

  logic              out_valid_r, degen_o_r;
  logic [15:0]       mx_o_r, my_o_r, sdx_o_r, sdy_o_r, corr_o_r;

  logic [OPND_W-1:0] n64, mul_a, mul_b, sq_v, p64;
  logic [DVD_W-1:0]  div_n;
  logic [DVS_W-1:0]  div_d;
  logic [PROD_W-1:0] mul_p;
  logic [QUO_W-1:0]  div_q;
  logic [ROOT_W-1:0] root;
  logic              is_mul, is_div, is_sq;
  logic              mul_done, div_done, sq_done;
  logic [16:0]       q17;
  logic [15:0]       qcap, corr_nxt;
  logic              degen;

  assign n64 = OPND_W'(cnt_r);
  assign p64 = mul_p[OPND_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    sq_v  = '0;
    case (cmd.op)
      OP_MEANX: begin
        div_n = DVD_W'(OPND_W'(sx_r) + (n64 >> 1));
        div_d = DVS_W'(n64);
      end
      OP_MEANY: begin
        div_n = DVD_W'(OPND_W'(sy_r) + (n64 >> 1));
        div_d = DVS_W'(n64);
      end
      OP_NSXX: begin mul_a = n64;            mul_b = OPND_W'(sxx_r); end
      OP_SXSX: begin mul_a = OPND_W'(sx_r);  mul_b = OPND_W'(sx_r);  end
      OP_NSYY: begin mul_a = n64;            mul_b = OPND_W'(syy_r); end
      OP_SYSY: begin mul_a = OPND_W'(sy_r);  mul_b = OPND_W'(sy_r);  end
      OP_NN:   begin mul_a = n64;            mul_b = n64;            end
      OP_DXNN: begin div_n = DVD_W'(dx_r);   div_d = DVS_W'(nn_r);   end
      OP_SQX:  sq_v = t1_r;
      OP_DYNN: begin div_n = DVD_W'(dy_r);   div_d = DVS_W'(nn_r);   end
      OP_SQY:  sq_v = t1_r;
      OP_NSXY: begin mul_a = n64;            mul_b = OPND_W'(sxy_r); end
      OP_SXSY: begin mul_a = OPND_W'(sx_r);  mul_b = OPND_W'(sy_r);  end
      OP_MAG2: begin mul_a = mag_r;          mul_b = mag_r;          end
      OP_DXDY: begin mul_a = dx_r;           mul_b = dy_r;           end
      OP_CDIV: begin div_n = num_r;          div_d = den_r;          end
      OP_CSQ:  sq_v = t1_r;
      default: ;
    endcase
  end

  always_comb begin
    is_mul = cmd.op inside {OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NN,
                            OP_NSXY, OP_SXSY, OP_MAG2, OP_DXDY};
    is_div = cmd.op inside {OP_MEANX, OP_MEANY, OP_DXNN, OP_DYNN, OP_CDIV};
    is_sq  = cmd.op inside {OP_SQX, OP_SQY, OP_CSQ};
  end

  bss_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && is_mul),
    .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  bss_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && is_div),
    .dvd(div_n), .dvs(div_d), .done(div_done), .quo(div_q)
  );

  bss_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.start && is_sq),
    .v(sq_v), .done(sq_done), .root(root)
  );

  // round half up, limit to one, then apply sign
  always_comb begin
    q17      = (root[16:0] + 17'd1) >> 1;
    qcap     = (q17 > 17'(CORR_ONE)) ? CORR_ONE : q17[15:0];
    corr_nxt = neg_r ? (16'd0 - qcap) : qcap;
  end

  assign degen = (dx_r == '0) || (dy_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (cmd.load_out) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (cmd.acc_en && cnt_r < MAX_CNT) begin
      cnt_r <= cnt_r + 1'b1;
      sx_r  <= sx_r + SUM_W'(x_sample);
      sy_r  <= sy_r + SUM_W'(y_sample);
      sxx_r <= sxx_r + SQ_W'(32'(x_sample) * 32'(x_sample));
      syy_r <= syy_r + SQ_W'(32'(y_sample) * 32'(y_sample));
      sxy_r <= sxy_r + SQ_W'(32'(x_sample) * 32'(y_sample));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      case (cmd.op)
        OP_MEANX: mx_r  <= div_q[15:0];
        OP_MEANY: my_r  <= div_q[15:0];
        OP_NSXX:  t1_r  <= p64;
        OP_SXSX:  dx_r  <= (t1_r > p64) ? t1_r - p64 : '0;
        OP_NSYY:  t1_r  <= p64;
        OP_SYSY:  dy_r  <= (t1_r > p64) ? t1_r - p64 : '0;
        OP_NN:    nn_r  <= p64;
        OP_DXNN:  t1_r  <= div_q;
        OP_SQX:   sdx_r <= root[15:0];
        OP_DYNN:  t1_r  <= div_q;
        OP_SQY:   sdy_r <= root[15:0];
        OP_NSXY:  t1_r  <= p64;
        OP_SXSY: begin
          neg_r <= t1_r < p64;
          mag_r <= (t1_r < p64) ? p64 - t1_r : t1_r - p64;
        end
        OP_MAG2:  num_r <= {mul_p[DVS_W-1:0], 30'd0};
        OP_DXDY:  den_r <= mul_p[DVS_W-1:0];
        OP_CDIV:  t1_r  <= div_q;
        OP_CSQ:   corr_r <= corr_nxt;
        default: ;
      endcase
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cnt_r == '0) begin
        mx_o_r    <= '0;
        my_o_r    <= '0;
        sdx_o_r   <= '0;
        sdy_o_r   <= '0;
        corr_o_r  <= '0;
        degen_o_r <= 1'b1;
      end else begin
        mx_o_r    <= mx_r;
        my_o_r    <= my_r;
        sdx_o_r   <= sdx_r;
        sdy_o_r   <= sdy_r;
        corr_o_r  <= degen ? 16'd0 : corr_r;
        degen_o_r <= degen;
      end
    end
  end

  always_comb begin
    stat.done     = mul_done || div_done || sq_done;
    stat.empty    = cnt_r == '0;
    stat.degen    = degen;
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid   = out_valid_r;
  assign mean_x_out  = mx_o_r;
  assign mean_y_out  = my_o_r;
  assign stdev_x_out = sdx_o_r;
  assign stdev_y_out = sdy_o_r;
  assign correlation = corr_o_r;
  assign degenerate  = degen_o_r;
endmodule

FILE: sv/bss_ctrl.sv
module bss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  bss_pkg::stat_t stat,
  output bss_pkg::cmd_t  cmd
);
  import bss_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      op_r    <= OP_MEANX;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    in_ready     = 1'b0;
    cmd.acc_en   = 1'b0;
    cmd.start    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.load_out = 1'b0;
    cmd.op       = op_r;
    case (state_r)
      ST_ACC: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_ISSUE;
          op_nxt    = OP_MEANX;
        end
      end
      ST_ISSUE: begin
        if (stat.empty) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          cmd.capture = 1'b1;
          case (op_r)
            OP_SQY: begin
              // skip the correlation when a deviation is zero
              if (stat.degen) begin
                state_nxt = ST_FIN;
              end else begin
                op_nxt    = OP_NSXY;
                state_nxt = ST_ISSUE;
              end
            end
            OP_CSQ: state_nxt = ST_FIN;
            default: begin
              op_nxt    = op_t'(op_r + 5'd1);
              state_nxt = ST_ISSUE;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end
endmodule

FILE: sv/bivariate_summary_statistics.sv
// Points are taken one a cycle while a set accumulates.
// After the point marked last the block takes no point until the result word
// is loaded; the statistics come from a shared bit-serial multiplier, divider
// and square root unit; the correlation is skipped when a deviation is zero.
// The result word then waits in an output register; the next set may start.
// Synchronous active-low reset clears the accumulators and the result valid.
module bivariate_summary_statistics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // x_sample[15:0], y_sample[31:16]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mean_x_out[15:0], mean_y_out[31:16], stdev_x_out[47:32],
  // stdev_y_out[63:48], correlation[79:64]
  output logic [79:0] out_tdata,
  output logic        out_tuser  // degenerate
);
  import bss_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [15:0]        mx, my, sdx, sdy;
  logic signed [15:0] corr;

  bss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_last(in_tlast), .in_ready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  bss_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .x_sample(in_tdata[15:0]), .y_sample(in_tdata[31:16]),
    .cmd(cmd), .stat(stat),
    .out_ready(out_tready), .out_valid(out_tvalid),
    .mean_x_out(mx), .mean_y_out(my),
    .stdev_x_out(sdx), .stdev_y_out(sdy),
    .correlation(corr), .degenerate(out_tuser)
  );

  assign out_tdata = {corr, sdy, sdx, my, mx};
endmodule

FILE: sv/bss_chk.sv
module bss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // the set closes: no point taken right after the last one
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("point accepted after last");

  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[79:64]) <= 16'sd16384 &&
                    $signed(out_tdata[79:64]) >= -16'sd16384))
    else $error("correlation beyond one");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[79:64] == 16'd0)
    else $error("degenerate set with nonzero correlation");

endmodule

bind bivariate_summary_statistics bss_chk u_bss_chk (.*);

FILE: dv/tb_bivariate_summary_statistics.sv
module tb_bivariate_summary_statistics;
  import bss_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int LONG_HOLD  = 3000;
  localparam int DRAIN_WAIT = 2000;

  typedef struct packed {
    logic [15:0]        mean_x;
    logic [15:0]        mean_y;
    logic [15:0]        sd_x;
    logic [15:0]        sd_y;
    logic signed [15:0] corr;
    logic               degen;
  } stats_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    bit          last;
    bit          typed;
    stats_t      res;
  } vec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        out_tuser;

  bivariate_summary_statistics i_dut (.*);

  // accumulator copy
  logic [CNT_W-1:0] pt_cnt;
  logic [27:0]      acc_x, acc_y;
  logic [43:0]      acc_xx, acc_yy, acc_xy;

  stats_t stats_q[$];
  vec_t   dir[$];
  int     errors;
  int     n_words, n_sets, n_degen, n_full;
  int     send_idle_pct, recv_stall_pct;
  bit     hold_req;
  int     idle_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] root64(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (64'(c) * 64'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] spread(logic [63:0] n, logic [63:0] s, logic [63:0] ss);
    logic [63:0] a;
    logic [63:0] b;
    a = n * ss;
    b = s * s;
    return (a > b) ? a - b : 64'd0;
  endfunction

  // advance the accumulators by one point unless full; gives the set statistics on last
  task automatic accumulate(input logic [15:0] x, input logic [15:0] y, input bit last,
                            output bit has_res, output stats_t r);
    logic [63:0]  n, dx, dy, a, b, mag, f, cand, q;
    logic [159:0] prod, rhs;
    bit           neg;
    has_res = 1'b0;
    r = '0;
    if (pt_cnt < MAX_CNT) begin
      pt_cnt = pt_cnt + 1'b1;
      acc_x  = acc_x + x;
      acc_y  = acc_y + y;
      acc_xx = acc_xx + 44'(x) * 44'(x);
      acc_yy = acc_yy + 44'(y) * 44'(y);
      acc_xy = acc_xy + 44'(x) * 44'(y);
    end else if (last) begin
      n_full++;
    end
    if (!last) return;
    has_res = 1'b1;
    n = 64'(pt_cnt);
    if (n == 0) begin
      r.degen = 1'b1;
    end else begin
      r.mean_x = 16'((64'(acc_x) + n / 2) / n);
      r.mean_y = 16'((64'(acc_y) + n / 2) / n);
      dx = spread(n, 64'(acc_x), 64'(acc_xx));
      dy = spread(n, 64'(acc_y), 64'(acc_yy));
      r.sd_x = 16'(root64(dx / (n * n)));
      r.sd_y = 16'(root64(dy / (n * n)));
      r.degen = (dx == 0) || (dy == 0);
      if (!r.degen) begin
        a = n * 64'(acc_xy);
        b = 64'(acc_x) * 64'(acc_y);
        neg = a < b;
        mag = neg ? b - a : a - b;
        prod = 160'(dx) * 160'(dy);
        rhs  = (160'(mag) * 160'(mag)) << 30;
        f = 0;
        // largest f with f*f*Dx*Dy <= 2^30*C*C, f up to one in Q1.15
        for (int bt = 15; bt >= 0; bt--) begin
          cand = f | (64'd1 << bt);
          if (cand <= 32768 && 160'(cand * cand) * prod <= rhs) f = cand;
        end
        q = (f + 1) / 2;
        if (q > 16384) q = 16384;
        r.corr = neg ? 16'(-q) : 16'(q);
      end
    end
    pt_cnt = '0;
    acc_x = '0; acc_y = '0; acc_xx = '0; acc_yy = '0; acc_xy = '0;
  endtask

  task automatic report(string field, logic [15:0] got, logic [15:0] exp_v);
    errors++;
    $display("mismatch on result %0d: %s got %h, expected %h", n_sets, field, got, exp_v);
  endtask

  // append one stimulus row
  task automatic add_row(logic [15:0] x, logic [15:0] y, bit last,
                         bit typed = 0, stats_t res = '0);
    vec_t v;
    v.x     = x;
    v.y     = y;
    v.last  = last;
    v.typed = typed;
    v.res   = res;
    dir.insert(dir.size(), v);
  endtask

  // offer one word and hold it until taken
  task automatic send_point(logic [15:0] x, logic [15:0] y, bit last,
                            bit typed = 0, stats_t typed_res = '0);
    bit     has_res;
    stats_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {y, x};
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate(x, y, last, has_res, r);
    if (has_res) stats_q.insert(stats_q.size(), typed ? typed_res : r);
    n_words++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_set(int size);
    int          kind;
    logic [15:0] x, y, base, cx;
    kind = $urandom_range(5);
    base = 16'($urandom);
    cx   = 16'($urandom);
    for (int i = 0; i < size; i++) begin
      x = 16'($urandom);
      y = 16'($urandom);
      case (kind)
        1: begin x = base + 16'($urandom_range(255)); y = x + 16'($urandom_range(63)); end
        2: y = ~x ^ 16'($urandom_range(127));
        3: x = cx;
        4: begin x = 16'($urandom_range(3)); y = 16'($urandom_range(3)); end
        default: ;
      endcase
      send_point(x, y, i == size - 1);
    end
  endtask

  task automatic random_sets(int words);
    int sent;
    int size;
    sent = 0;
    while (sent < words) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(100, 2) : $urandom_range(12, 1);
      send_set(size);
      sent += size;
    end
  endtask

  // result side
  initial begin
    stats_t got;
    stats_t exp_r;
    int     hold_left;
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
               out_tdata[79:64], out_tuser};
        n_sets++;
        if (got.degen) n_degen++;
        if (stats_q.size() == 0) begin
          errors++;
          $display("unexpected result word %h / %b", out_tdata, out_tuser);
        end else begin
          exp_r = stats_q.pop_front();
          if (got.mean_x !== exp_r.mean_x) report("mean_x", got.mean_x, exp_r.mean_x);
          if (got.mean_y !== exp_r.mean_y) report("mean_y", got.mean_y, exp_r.mean_y);
          if (got.sd_x !== exp_r.sd_x) report("stdev_x", got.sd_x, exp_r.sd_x);
          if (got.sd_y !== exp_r.sd_y) report("stdev_y", got.sd_y, exp_r.sd_y);
          if (got.corr !== exp_r.corr) report("correlation", got.corr, exp_r.corr);
          if (got.degen !== exp_r.degen) report("degenerate", 16'(got.degen), 16'(exp_r.degen));
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("no progress for %0d cycles, %0d results outstanding", idle_cnt,
                 stats_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    errors = 0; n_words = 0; n_sets = 0; n_degen = 0; n_full = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b0;
    pt_cnt = '0;
    acc_x = '0; acc_y = '0; acc_xx = '0; acc_yy = '0; acc_xy = '0;

    // single-point sets are degenerate, mean is the point itself
    add_row(16'h0000, 16'h0000, 1, 1, '{16'h0000, 16'h0000, 0, 0, 0, 1});
    add_row(16'hFFFF, 16'hFFFF, 1, 1, '{16'hFFFF, 16'hFFFF, 0, 0, 0, 1});
    add_row(16'hFFFF, 16'h0000, 1, 1, '{16'hFFFF, 16'h0000, 0, 0, 0, 1});
    // full-scale pair: correlation plus one, then minus one
    add_row(16'h0000, 16'h0000, 0);
    add_row(16'hFFFF, 16'hFFFF, 1, 1, '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                        16'sh4000, 0});
    add_row(16'h0000, 16'hFFFF, 0);
    add_row(16'hFFFF, 16'h0000, 1, 1, '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                        16'shC000, 0});
    // constant y: degenerate with a live x deviation
    add_row(16'h0100, 16'h1234, 0);
    add_row(16'h0300, 16'h1234, 0);
    add_row(16'h0800, 16'h1234, 1);
    // ordinary sets
    add_row(16'h5555, 16'hAAAA, 0);
    add_row(16'hAAAA, 16'h5555, 0);
    add_row(16'h0001, 16'h8000, 0);
    add_row(16'h8000, 16'h0001, 1);
    add_row(16'h0010, 16'h0020, 0);
    add_row(16'h0020, 16'h0041, 0);
    add_row(16'h0030, 16'h0060, 1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir[i]) send_point(dir[i].x, dir[i].y, dir[i].last, dir[i].typed, dir[i].res);

    // no idling
    random_sets(400);
    // let the output register fill and the input stall behind it
    hold_req = 1'b1;
    random_sets(60);
    wait (stats_q.size() == 0);
    send_idle_pct = 66;
    random_sets(400);
    send_idle_pct = 0; recv_stall_pct = 66;
    random_sets(400);
    send_idle_pct = 20; recv_stall_pct = 20;
    random_sets(400);

    wait (stats_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d points, checked %0d result words (%0d degenerate, %0d overfull)",
             n_words, n_sets, n_degen, n_full);
    if (errors == 0 && stats_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
sv/bss_pkg.sv
sv/bss_mul.sv
sv/bss_div.sv
sv/bss_sqrt.sv
sv/bss_dp.sv
sv/bss_ctrl.sv
sv/bivariate_summary_statistics.sv
sv/bss_chk.sv
dv/tb_bivariate_summary_statistics.sv
